>>> design/compass_heading_from_xy_core_macros.svh
// assertion macros shared by the compass heading core
// expects clk_i and rst_ni in the scope of each use
`ifndef COMPASS_HEADING_FROM_XY_CORE_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_CORE_MACROS_SVH

// same-cycle implication
`define CHXY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication
`define CHXY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/chxy_pkg.sv
// shared types and constants of the compass heading cordic pipeline
// no dependencies
package chxy_pkg;

  // vector and angle widths (angle in units of 2^-24 degree)
  localparam int XY_W      = 20;
  localparam int ACC_BITS  = 24;
  localparam int Z_W       = 34;
  localparam int TABLE_LEN = 24;

  // +180 degrees in accumulator units
  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180) << ACC_BITS;

  // atan(2^-i) in units of 2^-24 degree, rounded to nearest
  localparam logic [31:0] ARC_TABLE [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // exact headings that replace the rotation result
  typedef enum logic [2:0] {
    SPEC_NONE    = 3'd0,
    SPEC_ZERO    = 3'd1,
    SPEC_POS_180 = 3'd2,
    SPEC_POS_90  = 3'd3,
    SPEC_NEG_90  = 3'd4
  } spec_e;

  // one beat inside the rotation pipeline
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    spec_e                  spec;
  } vec_t;

endpackage

>>> design/chxy_fold.sv
// input stage: special-case detection and left half-plane fold
// depends on chxy_pkg
module chxy_fold (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [15:0]  field_x_i,
  input  logic signed [15:0]  field_y_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output chxy_pkg::vec_t      vec_o
);

  logic                            valid_q;
  chxy_pkg::vec_t                  vec_d, vec_q;
  logic signed [chxy_pkg::XY_W-1:0] x_ext, y_ext;

  assign x_ext = chxy_pkg::XY_W'(field_x_i);
  assign y_ext = chxy_pkg::XY_W'(field_y_i);

  // classify and fold negative x onto the right half plane
  always_comb begin
    vec_d.x    = x_ext;
    vec_d.y    = y_ext;
    vec_d.z    = '0;
    vec_d.spec = chxy_pkg::SPEC_NONE;
    if (field_y_i == 16'sd0) begin
      vec_d.spec = field_x_i[15] ? chxy_pkg::SPEC_POS_180 : chxy_pkg::SPEC_ZERO;
    end else if (field_x_i == 16'sd0) begin
      vec_d.spec = field_y_i[15] ? chxy_pkg::SPEC_NEG_90 : chxy_pkg::SPEC_POS_90;
    end else if (field_x_i[15]) begin
      vec_d.x = -x_ext;
      vec_d.y = -y_ext;
      vec_d.z = field_y_i[15] ? -chxy_pkg::Z_HALF_TURN : chxy_pkg::Z_HALF_TURN;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> design/chxy_rot_stage.sv
// one cordic vectoring micro-rotation with its pipeline register
// depends on chxy_pkg
module chxy_rot_stage #(
  parameter int SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  chxy_pkg::vec_t vec_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output chxy_pkg::vec_t vec_o
);

  localparam logic signed [chxy_pkg::Z_W-1:0] ARC =
    chxy_pkg::Z_W'(chxy_pkg::ARC_TABLE[SHIFT]);

  logic                             valid_q;
  chxy_pkg::vec_t                   vec_d, vec_q;
  logic signed [chxy_pkg::XY_W-1:0] xs, ys;
  logic                             rot_cw;

  assign xs     = vec_i.x >>> SHIFT;
  assign ys     = vec_i.y >>> SHIFT;
  assign rot_cw = !vec_i.y[chxy_pkg::XY_W-1] && (vec_i.y != '0);

  // drive y toward zero, accumulate the angle turned
  always_comb begin
    vec_d.spec = vec_i.spec;
    if (rot_cw) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ARC;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ARC;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

>>> design/chxy_finish.sv
// output stages: round the angle to the output grid, wrap, apply exact cases
// depends on chxy_pkg and the assertion macro header
`include "compass_heading_from_xy_core_macros.svh"

module chxy_finish #(
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  chxy_pkg::vec_t     vec_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] heading_o
);

  localparam int Z_W   = chxy_pkg::Z_W;
  localparam int SHR   = chxy_pkg::ACC_BITS - ANGLE_FRACTION_BITS;
  localparam logic [Z_W-1:0] RND  = Z_W'(1) << (SHR - 1);
  localparam logic [Z_W-1:0] HALF = Z_W'(180) << ANGLE_FRACTION_BITS;
  localparam logic [Z_W-1:0] TURN = HALF << 1;
  localparam logic signed [Z_W-1:0] HALF_S = signed'(HALF);
  localparam logic signed [Z_W-1:0] QUART_S = signed'(HALF >> 1);

  // rounding stage
  logic             a_valid_q, a_ready;
  logic [Z_W-1:0]   zt, addend, m_d, m_q;
  logic             neg_q;
  chxy_pkg::spec_e  spec_q;

  // output stage
  logic                  b_valid_q, b_ready;
  logic signed [Z_W-1:0] res_d, res_q;
  logic                  wrap;

  // |z| rounded half away from zero: ~z + (rnd + 1) for negative z, one adder
  assign zt     = vec_i.z[Z_W-1] ? ~vec_i.z : vec_i.z;
  assign addend = vec_i.z[Z_W-1] ? RND + Z_W'(1) : RND;
  assign m_d    = (zt + addend) >> SHR;

  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      m_q    <= m_d;
      neg_q  <= vec_i.z[Z_W-1];
      spec_q <= vec_i.spec;
    end
  end

  // restore sign and wrap into -180..+180, or take an exact heading
  assign wrap = m_q > HALF;

  always_comb begin
    case (spec_q)
      chxy_pkg::SPEC_ZERO:    res_d = '0;
      chxy_pkg::SPEC_POS_180: res_d = HALF_S;
      chxy_pkg::SPEC_POS_90:  res_d = QUART_S;
      chxy_pkg::SPEC_NEG_90:  res_d = -QUART_S;
      default: begin
        if (wrap) begin
          res_d = neg_q ? signed'(TURN - m_q) : signed'(m_q - TURN);
        end else begin
          res_d = neg_q ? -signed'(m_q) : signed'(m_q);
        end
      end
    endcase
  end

  assign b_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      res_q <= res_d;
    end
  end

  assign valid_o   = b_valid_q;
  assign heading_o = res_q[15:0];

  // checks
  `CHXY_ASSERT(a_res_in_range, b_valid_q |-> (res_q <= HALF_S && res_q >= -HALF_S), "heading outside -180..+180")
  `CHXY_ASSERT(a_mag_below_turn, (a_valid_q && spec_q == chxy_pkg::SPEC_NONE) |-> (m_q < TURN), "rounded angle magnitude reaches a full turn")
  `CHXY_ASSERT_NEXT(a_round_to_out, a_valid_q && b_ready, b_valid_q, "rounded beat lost on the way to the output register")

endmodule

>>> design/compass_heading_from_xy_core.sv
// Compass heading core: each beat of signed 16-bit field_x/field_y gives one beat of
// heading = atan2(field_y, field_x) in 1/2^ANGLE_FRACTION_BITS degree, -180..+180
// (y = 0, x < 0 gives exactly +180; x = y = 0 gives 0). The angle comes from an
// unrolled CORDIC in vectoring mode, one micro-rotation per register stage, so the
// block takes one beat every clock unless all stages hold a beat. A beat passes
// one fold stage, ROTATION_STEPS rotation stages and two rounding/wrap stages,
// in that order. Every stage has its own valid bit, so bubbles
// close up under a stall and input is refused only when all stages hold a beat.
// depends on chxy_pkg, chxy_fold, chxy_rot_stage, chxy_finish and the macro header
`include "compass_heading_from_xy_core_macros.svh"

module compass_heading_from_xy_core #(
  parameter int ROTATION_STEPS      = 16,
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] field_x_i,
  input  logic signed [15:0] field_y_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] heading_o
);

  chxy_pkg::vec_t          vec   [ROTATION_STEPS+1];
  logic [ROTATION_STEPS:0] vld;
  logic [ROTATION_STEPS:0] rdy;
  logic                    fold_ready;

  // half-plane fold
  chxy_fold u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .field_x_i (field_x_i),
    .field_y_i (field_y_i),
    .ready_o   (fold_ready),
    .valid_o   (vld[0]),
    .ready_i   (rdy[0]),
    .vec_o     (vec[0])
  );

  assign stall_o = !fold_ready;

  // micro-rotation chain
  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
    chxy_rot_stage #(
      .SHIFT (i)
    ) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .vec_i   (vec[i]),
      .ready_o (rdy[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .vec_o   (vec[i+1])
    );
  end

  // rounding, wrap and output register
  chxy_finish #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld[ROTATION_STEPS]),
    .vec_i     (vec[ROTATION_STEPS]),
    .ready_o   (rdy[ROTATION_STEPS]),
    .valid_o   (valid_o),
    .ready_i   (!stall_i),
    .heading_o (heading_o)
  );

  // checks
  `CHXY_ASSERT(a_flow_when_drained, !stall_i |-> !stall_o, "input stalled while output flows")
  `CHXY_ASSERT(a_ready_chain, (rdy[ROTATION_STEPS] && !vld[0]) |-> !stall_o, "empty fold stage refuses a beat")

endmodule
